[hw/rtl/scdl_pkg.sv]
// Shared types, codes and sizes for the serial crossover delay link.
package scdl_pkg;

	// Default depth of each end's outbound ring
	localparam int RING_DEPTH_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LATENCY   = CFG_IDX_W'(1);

	// Link wiring codes
	localparam logic [1:0] LINK_NULL  = 2'd0;
	localparam logic [1:0] LINK_LOOP  = 2'd1;
	localparam logic [1:0] LINK_CROSS = 2'd2;

	// Operation codes
	localparam logic [2:0] OP_SEND  = 3'd0;
	localparam logic [2:0] OP_RECV  = 3'd1;
	localparam logic [2:0] OP_LINES = 3'd2;
	localparam logic [2:0] OP_RESET = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0]  mode;
		logic        end_select;
		logic [7:0]  tx_byte;
		logic [63:0] now_cycle;
		logic [31:0] line_bits;
	} cmd_t;

	typedef struct packed {
		logic        tx_accepted;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic        head_pending;
		logic [63:0] head_due;
		logic [31:0] peer_lines;
		logic        connected;
	} result_t;

	// One ring slot
	typedef struct packed {
		logic [7:0]  data;
		logic [63:0] due;
	} ring_entry_t;

endpackage

[hw/rtl/scdl_ring_ram.sv]
// Ring slot memory: one write port, one registered read port, write-first on collision.
module scdl_ring_ram #(
	parameter int RING_DEPTH = scdl_pkg::RING_DEPTH_DEF,
	parameter int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [IDX_W-1:0]          waddr,
	input  scdl_pkg::ring_entry_t     wdata,
	input  logic [IDX_W-1:0]          raddr,
	output scdl_pkg::ring_entry_t     rdata
);

	scdl_pkg::ring_entry_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// bypass so a slot written this cycle is seen as the new head
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/serial_crossover_delay_link_core.sv]
// Top level of the serial crossover delay link: two delayed byte rings and line registers.
//
// Channel   Direction  Handshake                      Payload
// command   in         start & !busy                  cmd    (scdl_pkg::cmd_t)
// result    out        done strobe, one cycle         result (scdl_pkg::result_t)
// config    in         cfg_valid & cfg_ready          cfg_index, cfg_data
//
// One command transaction is taken every cycle; busy stays low.
// The result passes through the input register, then the result register. Each ring
// keeps its head slot in the registered read port of its memory, read ahead at the
// head of the updated state, so back-to-back receives need no stall.
// Asynchronous active-low reset empties both rings, clears lines, config, valid and done.
// The receiver cannot stall: each result is shown for exactly one cycle.
module serial_crossover_delay_link_core #(
	parameter int RING_DEPTH = scdl_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  scdl_pkg::cmd_t                 cmd,
	output logic                           done,
	output scdl_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers
	logic [1:0]  link_mode_q;
	logic [31:0] latency_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= scdl_pkg::LINK_NULL;
			latency_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scdl_pkg::CFG_LINK_MODE: link_mode_q <= cfg_data[1:0];
				scdl_pkg::CFG_LATENCY:   latency_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	logic           valid_s1;
	scdl_pkg::cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// Per-end ring control and lines; index 1 is end A, index 0 is end B
	logic [IDX_W-1:0] head_q    [2];
	logic [CNT_W-1:0] count_q   [2];
	logic [31:0]      lines_q   [2];
	logic [IDX_W-1:0] head_nxt  [2];
	logic [CNT_W-1:0] count_nxt [2];
	logic [31:0]      lines_nxt [2];
	logic [IDX_W-1:0] head_inc  [2];
	logic [IDX_W-1:0] tail      [2];
	logic             ram_we    [2];
	scdl_pkg::ring_entry_t head_ent [2];
	scdl_pkg::ring_entry_t wr_ent;

	logic live;
	logic me;
	logic inb;
	logic push_ok;
	logic pop_ok;

	assign live = link_mode_q inside {scdl_pkg::LINK_LOOP, scdl_pkg::LINK_CROSS};
	assign me   = cmd_s1.end_select;
	assign inb  = (link_mode_q == scdl_pkg::LINK_CROSS) ? ~me : me;

	assign wr_ent.data = cmd_s1.tx_byte;
	assign wr_ent.due  = cmd_s1.now_cycle + {32'd0, latency_q};

	always_comb begin
		logic [SUM_W-1:0] sum;
		for (int e = 0; e < 2; e++) begin
			sum = SUM_W'(head_q[e]) + SUM_W'(count_q[e]);
			if (sum >= SUM_W'(RING_DEPTH)) begin
				sum = sum - SUM_W'(RING_DEPTH);
			end
			tail[e]     = sum[IDX_W-1:0];
			head_inc[e] = (head_q[e] == IDX_W'(RING_DEPTH - 1)) ? '0 : head_q[e] + IDX_W'(1);
		end
	end

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			head_nxt[e]  = head_q[e];
			count_nxt[e] = count_q[e];
			lines_nxt[e] = lines_q[e];
			ram_we[e]    = 1'b0;
		end
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		if (valid_s1 && live) begin
			case (cmd_s1.mode)
				scdl_pkg::OP_SEND: begin
					if (count_q[me] < CNT_W'(RING_DEPTH)) begin
						push_ok       = 1'b1;
						ram_we[me]    = 1'b1;
						count_nxt[me] = count_q[me] + CNT_W'(1);
					end
				end
				scdl_pkg::OP_RECV: begin
					if ((count_q[inb] != '0) && (head_ent[inb].due <= cmd_s1.now_cycle)) begin
						pop_ok         = 1'b1;
						head_nxt[inb]  = head_inc[inb];
						count_nxt[inb] = count_q[inb] - CNT_W'(1);
					end
				end
				scdl_pkg::OP_LINES: begin
					lines_nxt[me] = cmd_s1.line_bits;
				end
				scdl_pkg::OP_RESET: begin
					head_nxt[me]  = '0;
					count_nxt[me] = '0;
					lines_nxt[me] = '0;
				end
				default: ; // query and unused codes leave state alone
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 2; e++) begin
				head_q[e]  <= '0;
				count_q[e] <= '0;
				lines_q[e] <= '0;
			end
		end else begin
			for (int e = 0; e < 2; e++) begin
				head_q[e]  <= head_nxt[e];
				count_q[e] <= count_nxt[e];
				lines_q[e] <= lines_nxt[e];
			end
		end
	end

	// Ring memories; the read port always tracks the head of the updated state
	for (genvar g = 0; g < 2; g++) begin : g_ring
		scdl_ring_ram #(
			.RING_DEPTH (RING_DEPTH),
			.IDX_W      (IDX_W)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (tail[g]),
			.wdata (wr_ent),
			.raddr (head_nxt[g]),
			.rdata (head_ent[g])
		);
	end

	// Result register; head_due is taken from the read-ahead head next cycle
	logic        done_q;
	logic        tx_acc_q;
	logic        rx_valid_q;
	logic [7:0]  rx_byte_q;
	logic        pending_q;
	logic        inb_q;
	logic [31:0] seen_q;
	logic        conn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tx_acc_q   <= push_ok;
			rx_valid_q <= pop_ok;
			rx_byte_q  <= pop_ok ? head_ent[inb].data : 8'd0;
			pending_q  <= live && (count_nxt[inb] != '0);
			inb_q      <= inb;
			seen_q     <= live ? lines_nxt[inb] : 32'd0;
			conn_q     <= live;
		end
	end

	assign done = done_q;

	always_comb begin
		result.tx_accepted  = tx_acc_q;
		result.rx_valid     = rx_valid_q;
		result.rx_byte      = rx_byte_q;
		result.head_pending = pending_q;
		result.head_due     = pending_q ? head_ent[inb_q].due : 64'd0;
		result.peer_lines   = seen_q;
		result.connected    = conn_q;
	end

	// Assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= CNT_W'(RING_DEPTH)) && (count_q[1] <= CNT_W'(RING_DEPTH)))
		else $error("ring count exceeds depth");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted transaction produced no result two cycles later");

	a_null_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.connected) |->
		(!result.tx_accepted && !result.rx_valid && !result.head_pending))
		else $error("null link reported activity");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.tx_accepted && result.rx_valid))
		else $error("send and receive reported in one transaction");

endmodule
